// ----- rtl/record_sort_by_selected_key_core_defines.svh -----
// ----------------------------------------------------------------------------
// record sort core assertion macros
// shared concurrent assertion forms for the record sort blocks
// ----------------------------------------------------------------------------
`ifndef RECORD_SORT_BY_SELECTED_KEY_CORE_DEFINES_SVH
`define RECORD_SORT_BY_SELECTED_KEY_CORE_DEFINES_SVH

// same-cycle implication, held off during reset
`define RSK_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rsk assertion failed");

// next-cycle implication, held off during reset
`define RSK_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rsk assertion failed");

`endif

// ----- rtl/rsk_pkg.sv -----
// ----------------------------------------------------------------------------
// rsk_pkg
// types, constants and key helpers shared by the record sort blocks
// ----------------------------------------------------------------------------
package rsk_pkg;

   localparam int MAX_RECORDS_DEF = 64;
   localparam int STAT_W          = 16;
   // run length field, wide enough for the default capacity
   localparam int CNT_W           = 7;
   localparam int KEY_SEL_W       = 3;
   localparam int CSR_IDX_W       = 2;
   localparam int CSR_DATA_W      = 3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_SELECT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ASCENDING  = 2'd1;

   // key selector codes
   localparam logic [KEY_SEL_W-1:0] KEY_HP   = 3'd0;
   localparam logic [KEY_SEL_W-1:0] KEY_SP   = 3'd1;
   localparam logic [KEY_SEL_W-1:0] KEY_STR  = 3'd2;
   localparam logic [KEY_SEL_W-1:0] KEY_STAM = 3'd3;
   localparam logic [KEY_SEL_W-1:0] KEY_MAG  = 3'd4;
   localparam logic [KEY_SEL_W-1:0] KEY_LUK  = 3'd5;

   // one record, tag in the lowest bits
   typedef struct packed {
      logic [STAT_W-1:0] luk;
      logic [STAT_W-1:0] mag;
      logic [STAT_W-1:0] stam;
      logic [STAT_W-1:0] str;
      logic [STAT_W-1:0] sp;
      logic [STAT_W-1:0] hp;
      logic [STAT_W-1:0] tag;
   } rec_type;

   localparam int RECORD_W = $bits(rec_type);

   // one finished set waiting for the sorter
   typedef struct packed {
      logic [CNT_W-1:0] count;
      logic             ovf;
      logic             bank;
   } desc_type;

   // key of a record for a selector, unused codes give zero
   function automatic logic [STAT_W-1:0] key_of(rec_type r, logic [KEY_SEL_W-1:0] sel);
      logic [STAT_W-1:0] k;
      unique case (sel)
         KEY_HP:   k = r.hp;
         KEY_SP:   k = r.sp;
         KEY_STR:  k = r.str;
         KEY_STAM: k = r.stam;
         KEY_MAG:  k = r.mag;
         KEY_LUK:  k = r.luk;
         default:  k = '0;
      endcase
      return k;
   endfunction

   // strict ordering test, equal keys never move
   function automatic logic goes_before(logic [STAT_W-1:0] ka, logic [STAT_W-1:0] kb,
                                        logic asc);
      return asc ? (ka < kb) : (ka > kb);
   endfunction

endpackage

// ----- rtl/rsk_store.sv -----
// ----------------------------------------------------------------------------
// rsk_store
// two-bank record memory, one write port and one registered read port
// ----------------------------------------------------------------------------
module rsk_store #(
   parameter int AW = 6
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW:0]      wr_addr,
   input  rsk_pkg::rec_type wr_data,
   input  logic             rd_en,
   input  logic [AW:0]      rd_addr,
   output rsk_pkg::rec_type rd_data
);
   import rsk_pkg::*;

   localparam int DEPTH = 2 ** (AW + 1);

   rec_type mem [DEPTH];
   rec_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/rsk_queue.sv -----
// ----------------------------------------------------------------------------
// rsk_queue
// two-entry queue of finished sets, one per memory bank
// ----------------------------------------------------------------------------
module rsk_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  rsk_pkg::desc_type push_desc,
   input  logic              pop,
   output rsk_pkg::desc_type head,
   output logic              empty,
   output logic              full
);
   import rsk_pkg::*;

   desc_type   ent_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] fill_ff;
   logic [1:0] fill_in;

   assign empty = (fill_ff == 2'd0);
   assign full  = (fill_ff == 2'd2);
   assign head  = ent_ff[rd_ptr_ff];

   // occupancy
   always_comb begin
      fill_in = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 2'd1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   // pointers and fill
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         fill_ff <= fill_in;
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
      end
   end

   // entries
   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= push_desc;
      end
   end

endmodule

// ----- rtl/rsk_front.sv -----
// ----------------------------------------------------------------------------
// rsk_front
// takes record beats, stores them in the fill bank, hands finished sets on
// ----------------------------------------------------------------------------
module rsk_front #(
   parameter int MAX_RECORDS = rsk_pkg::MAX_RECORDS_DEF,
   parameter int AW          = $clog2(MAX_RECORDS)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [rsk_pkg::RECORD_W-1:0] req_tdata,
   input  logic                         req_tlast,
   input  logic                         q_full,
   output logic                         push,
   output rsk_pkg::desc_type            push_desc,
   output logic                         wr_en,
   output logic [AW:0]                  wr_addr,
   output rsk_pkg::rec_type             wr_data
);
   import rsk_pkg::*;

   localparam int CW = $clog2(MAX_RECORDS + 1);

   logic [CW-1:0] cnt_ff;
   logic [CW-1:0] cnt_in;
   logic          ovf_ff;
   logic          ovf_in;
   logic          bank_ff;
   logic          accept;
   logic          room;

   // a free bank exists whenever the queue has a slot
   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;
   assign room       = (cnt_ff < CW'(MAX_RECORDS));

   // store or drop the beat
   assign wr_en   = accept && room;
   assign wr_addr = {bank_ff, cnt_ff[AW-1:0]};
   assign wr_data = rec_type'(req_tdata);

   assign cnt_in = room ? (cnt_ff + CW'(1)) : cnt_ff;
   assign ovf_in = ovf_ff | !room;

   // hand the set over on the last beat
   assign push            = accept && req_tlast;
   assign push_desc.count = CNT_W'(cnt_in);
   assign push_desc.ovf   = ovf_in;
   assign push_desc.bank  = bank_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         ovf_ff  <= 1'b0;
         bank_ff <= 1'b0;
      end else if (accept) begin
         if (req_tlast) begin
            cnt_ff  <= '0;
            ovf_ff  <= 1'b0;
            bank_ff <= ~bank_ff;
         end else begin
            cnt_ff <= cnt_in;
            ovf_ff <= ovf_in;
         end
      end
   end

endmodule

// ----- rtl/rsk_back.sv -----
// ----------------------------------------------------------------------------
// rsk_back
// stable selection sort over one stored set, one result per memory scan
// ----------------------------------------------------------------------------
`include "record_sort_by_selected_key_core_defines.svh"

module rsk_back #(
   parameter int MAX_RECORDS = rsk_pkg::MAX_RECORDS_DEF,
   parameter int AW          = $clog2(MAX_RECORDS)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [rsk_pkg::KEY_SEL_W-1:0] key_sel,
   input  logic                          ascending,
   input  logic                          q_empty,
   input  rsk_pkg::desc_type             q_head,
   output logic                          q_pop,
   output logic                          rd_en,
   output logic [AW:0]                   rd_addr,
   input  rsk_pkg::rec_type              rd_data,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output rsk_pkg::rec_type              rsp_tdata,
   output logic                          rsp_tlast,
   output logic                          rsp_tuser
);
   import rsk_pkg::*;

   localparam int SLOTS = 2 ** AW;

   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_EMIT} state_type;

   state_type         state_ff;
   logic [CNT_W-1:0]  iss_cnt_ff;
   logic [CNT_W-1:0]  pos_ff;
   logic              cmp_vld_ff;
   logic [AW-1:0]     cmp_idx_ff;
   logic [SLOTS-1:0]  taken_ff;
   logic              have_best_ff;
   logic [AW-1:0]     best_idx_ff;
   logic [STAT_W-1:0] best_key_ff;
   rec_type           best_rec_ff;
   logic              rsp_tvalid_ff;
   rec_type           rsp_rec_ff;
   logic              rsp_tlast_ff;
   logic              rsp_tuser_ff;

   logic [CNT_W-1:0]  run_n;
   logic              issue;
   logic [STAT_W-1:0] cand_key;
   logic              better;
   logic              scan_last;
   logic              out_free;
   logic              last_pos;
   logic              best_open;

   assign run_n = q_head.count;

   // read one entry per cycle during a scan
   assign issue   = (state_ff == ST_SCAN) && (iss_cnt_ff < run_n);
   assign rd_en   = issue;
   assign rd_addr = {q_head.bank, iss_cnt_ff[AW-1:0]};

   // compare the returned entry with the best so far, ties keep the earlier one
   assign cand_key  = key_of(rd_data, key_sel);
   assign better    = !taken_ff[cmp_idx_ff] &&
                      (!have_best_ff || goes_before(cand_key, best_key_ff, ascending));
   assign scan_last = cmp_vld_ff && (CNT_W'(cmp_idx_ff) == (run_n - CNT_W'(1)));

   assign out_free = !rsp_tvalid_ff || rsp_tready;
   assign last_pos = (pos_ff == (run_n - CNT_W'(1)));
   assign q_pop    = (state_ff == ST_EMIT) && out_free && last_pos;

   // a chosen record that has not been sent yet
   assign best_open = have_best_ff && !taken_ff[best_idx_ff];

   // sequencer, scan pipeline and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         iss_cnt_ff    <= '0;
         pos_ff        <= '0;
         cmp_vld_ff    <= 1'b0;
         taken_ff      <= '0;
         have_best_ff  <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         if (rsp_tvalid_ff && rsp_tready && (state_ff != ST_EMIT)) begin
            rsp_tvalid_ff <= 1'b0;
         end

         cmp_vld_ff <= issue;
         cmp_idx_ff <= iss_cnt_ff[AW-1:0];
         if (issue) begin
            iss_cnt_ff <= iss_cnt_ff + CNT_W'(1);
         end

         if (cmp_vld_ff && better) begin
            have_best_ff <= 1'b1;
            best_idx_ff  <= cmp_idx_ff;
            best_key_ff  <= cand_key;
            best_rec_ff  <= rd_data;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (!q_empty) begin
                  taken_ff     <= '0;
                  pos_ff       <= '0;
                  iss_cnt_ff   <= '0;
                  have_best_ff <= 1'b0;
                  state_ff     <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               if (scan_last) begin
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (out_free) begin
                  rsp_tvalid_ff         <= 1'b1;
                  rsp_rec_ff            <= best_rec_ff;
                  rsp_tuser_ff          <= q_head.ovf;
                  rsp_tlast_ff          <= last_pos;
                  taken_ff[best_idx_ff] <= 1'b1;
                  have_best_ff          <= 1'b0;
                  iss_cnt_ff            <= '0;
                  if (last_pos) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     pos_ff   <= pos_ff + CNT_W'(1);
                     state_ff <= ST_SCAN;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_rec_ff;
   assign rsp_tlast  = rsp_tlast_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   // checks on the sort sequencer
   `RSK_ASSERT_IMPL(a_cmp_in_range, clock, reset, cmp_vld_ff, CNT_W'(cmp_idx_ff) < run_n)
   `RSK_ASSERT_IMPL(a_emit_has_best, clock, reset, state_ff == ST_EMIT, best_open)
   `RSK_ASSERT_NEXT(a_pop_ends_run, clock, reset, q_pop, rsp_tvalid_ff && rsp_tlast_ff)
   `RSK_ASSERT_IMPL(a_run_held, clock, reset, state_ff != ST_IDLE, !q_empty && (run_n != '0))

endmodule

// ----- rtl/record_sort_by_selected_key_core.sv -----
// ----------------------------------------------------------------------------
// record_sort_by_selected_key_core
// stable sort of a set of records on a selectable stat
// ----------------------------------------------------------------------------
// Records are taken one beat per cycle while req_tready is high and are
// written to a fill bank of a two-bank memory; req_tlast closes the set,
// and beats past MAX_RECORDS are dropped and reported on rsp_tuser of every
// result of that set. The sorter then scans the stored set once per result
// through the single read port of the memory, so a set of n records gives
// its n results through one full scan of n reads plus a compare and an emit
// for each result. While a set is being sorted the next set loads into the
// other bank; req_tready drops only while both banks hold sets whose results
// are not all out. key_select and ascending are sampled during the sort and
// are to be written only while the block is idle.
// ----------------------------------------------------------------------------
module record_sort_by_selected_key_core #(
   parameter int MAX_RECORDS = rsk_pkg::MAX_RECORDS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   // req_tdata: record_tag, stat_hp, stat_sp, stat_str, stat_stam, stat_mag, stat_luk
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [rsk_pkg::RECORD_W-1:0]   req_tdata,
   input  logic                           req_tlast,
   // rsp_tdata: out_tag, out_hp, out_sp, out_str, out_stam, out_mag, out_luk
   // rsp_tuser: overflowed
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [rsk_pkg::RECORD_W-1:0]   rsp_tdata,
   output logic                           rsp_tlast,
   output logic                           rsp_tuser,
   // register writes
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [rsk_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rsk_pkg::CSR_DATA_W-1:0] csr_data
);
   import rsk_pkg::*;

   localparam int AW = $clog2(MAX_RECORDS);

   logic [KEY_SEL_W-1:0] key_sel_ff;
   logic                 asc_ff;

   logic                 q_full;
   logic                 q_empty;
   logic                 q_push;
   logic                 q_pop;
   desc_type             push_desc;
   desc_type             q_head;
   logic                 wr_en;
   logic [AW:0]          wr_addr;
   rec_type              wr_data;
   logic                 rd_en;
   logic [AW:0]          rd_addr;
   rec_type              rd_data;
   rec_type              rsp_rec;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_sel_ff <= '0;
         asc_ff     <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_KEY_SELECT: key_sel_ff <= csr_data;
            CSR_ASCENDING:  asc_ff     <= csr_data[0];
            default:        ;
         endcase
      end
   end

   // front: load side
   rsk_front #(
      .MAX_RECORDS (MAX_RECORDS),
      .AW          (AW)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_full     (q_full),
      .push       (q_push),
      .push_desc  (push_desc),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data)
   );

   // finished sets
   rsk_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_desc (push_desc),
      .pop       (q_pop),
      .head      (q_head),
      .empty     (q_empty),
      .full      (q_full)
   );

   // record memory
   rsk_store #(
      .AW (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // back: sort and emit side
   rsk_back #(
      .MAX_RECORDS (MAX_RECORDS),
      .AW          (AW)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .key_sel    (key_sel_ff),
      .ascending  (asc_ff),
      .q_empty    (q_empty),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_rec),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   assign rsp_tdata = rsp_rec;

endmodule
